// File: src/box_blur_3x3_rgb_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// same-cycle implication
`define BB3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur check failed");

// next-cycle implication
`define BB3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur check failed");

`endif

// File: src/bb3_pkg.sv
// ---------------------------------------------------------------------------
// bb3_pkg
// Shared constants and controller/datapath interface types of the box blur.
// ---------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W   = $clog2(MAX_WIDTH);      // column index
    localparam int WCFG_W  = 11;                      // image_width register
    localparam int HCFG_W  = 13;                      // image_height register
    localparam int OROW_W  = $clog2(MAX_HEIGHT);      // output row
    localparam int IROW_W  = OROW_W + 1;              // input row runs past frame
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int NUM_W   = SUM_W + 1;
    localparam int DEN_W   = CNT_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W  = 4;
    localparam int ADDR_W  = 3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic accept;
        logic upd;
        logic sum_cap;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic emit;
        logic ci_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: src/bb3_datapath.sv
// ---------------------------------------------------------------------------
// bb3_datapath
// Line stores, 3x3 window, position counters, window sums, divider, output.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bb3_pkg::cmd_t               cmd,
    output bb3_pkg::status_t                 status,
    input  wire logic [23:0]                 s_tdata,   // blue, green, red
    input  wire logic                        s_tuser,   // mode
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata,   // blue, green, red
    output logic                             m_tlast,   // frame_end
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bb3_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata
);
    import bb3_pkg::*;

    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [IROW_W-1:0] in_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [OROW_W-1:0] out_row_reg;

    logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  rd_upper_reg;
    logic [PIX_W-1:0]  rd_lower_reg;
    logic [PIX_W-1:0]  win_reg [9];

    logic [PIX_W-1:0]  pix_reg;
    logic [COL_W-1:0]  ci_reg;
    logic [IROW_W-1:0] ri_reg;
    logic              emit_reg;

    logic [SUM_W-1:0]  sum_reg [3];
    logic [CNT_W-1:0]  n_reg;
    logic [NUM_W-1:0]  num_reg [3];
    logic [DEN_W-1:0]  rem_reg [3];
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic [WCFG_W-1:0] weff;
    logic [HCFG_W-1:0] heff;
    logic [COL_W-1:0]  ci_comb;
    logic              past;
    logic              emit_comb;
    logic              wr_en;
    logic [WCFG_W-1:0] col_inc;
    logic [1:0]        first_col;
    logic              top_ok;
    logic              bot_ok;
    logic [SUM_W-1:0]  sum_comb [3];
    logic [CNT_W-1:0]  n_comb;
    logic              last_px;

    assign wr_en = psel && penable && pwrite;

    // clamp sizes to 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            weff = WCFG_W'(1);
        else if (width_reg > WCFG_W'(MAX_WIDTH))
            weff = WCFG_W'(MAX_WIDTH);
        else
            weff = width_reg;
        if (height_reg == '0)
            heff = HCFG_W'(1);
        else if (height_reg > HCFG_W'(MAX_HEIGHT))
            heff = HCFG_W'(MAX_HEIGHT);
        else
            heff = height_reg;
    end

    always_comb
    begin
        if ({1'b0, in_col_reg} >= weff)
            ci_comb = COL_W'(weff - WCFG_W'(1));
        else
            ci_comb = in_col_reg;
    end

    assign past      = {1'b0, in_row_reg} >= {1'b0, heff};
    assign emit_comb = (in_row_reg >= IROW_W'(2)) ||
                       (in_row_reg == IROW_W'(1) && ci_comb != '0);

    assign status.drop     = !past && (s_tuser == MODE_DRAIN);
    assign status.emit     = emit_reg;
    assign status.ci_zero  = (ci_reg == '0);
    assign status.div_done = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.out_free = !out_valid_reg || m_tready;

    assign prdata = paddr[2] ? {{(32-HCFG_W){1'b0}}, height_reg}
                             : {{(32-WCFG_W){1'b0}}, width_reg};

    // line stores: registered read at accept, write during update
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_upper_reg <= upper_mem[ci_comb];
            rd_lower_reg <= lower_mem[ci_comb];
        end
        if (cmd.upd)
        begin
            upper_mem[ci_reg] <= rd_lower_reg;
            lower_mem[ci_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg  <= past ? '0 : s_tdata;
            ci_reg   <= ci_comb;
            ri_reg   <= in_row_reg;
            emit_reg <= emit_comb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (cmd.upd)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= rd_upper_reg;
            win_reg[5] <= rd_lower_reg;
            win_reg[8] <= pix_reg;
        end
    end

    assign col_inc = {1'b0, ci_reg} + WCFG_W'(1);
    assign last_px = ({1'b0, out_row_reg} + HCFG_W'(1) >= heff) &&
                     ({1'b0, out_col_reg} + WCFG_W'(1) >= weff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WCFG_W'(1024);
            height_reg  <= HCFG_W'(768);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_HEIGHT)
                height_reg <= pwdata[HCFG_W-1:0];
            else
                width_reg <= pwdata[WCFG_W-1:0];
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (cmd.upd)
            begin
                if (col_inc >= weff)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= ri_reg + IROW_W'(1);
                end
                else
                    in_col_reg <= col_inc[COL_W-1:0];
            end
            if (cmd.out_load)
            begin
                if (last_px)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else if ({1'b0, out_col_reg} + WCFG_W'(1) >= weff)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + OROW_W'(1);
                end
                else
                    out_col_reg <= out_col_reg + COL_W'(1);
            end
        end
    end

    // window column range: centre at last column uses the pre-shift window
    always_comb
    begin
        if (ci_reg == '0)
            first_col = (weff >= WCFG_W'(2)) ? 2'd1 : 2'd2;
        else
            first_col = (ci_reg >= COL_W'(2)) ? 2'd0 : 2'd1;
    end

    assign top_ok = (out_row_reg != '0);
    assign bot_ok = ({1'b0, out_row_reg} + HCFG_W'(1)) < heff;

    always_comb
    begin
        logic use_px;
        for (int c = 0; c < 3; c++)
            sum_comb[c] = '0;
        n_comb = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                use_px = (2'(k) >= first_col) && !(r == 0 && !top_ok) &&
                         !(r == 2 && !bot_ok);
                if (use_px)
                begin
                    for (int c = 0; c < 3; c++)
                        sum_comb[c] = sum_comb[c] + SUM_W'(win_reg[r*3+k][c*CH_W +: CH_W]);
                    n_comb = n_comb + CNT_W'(1);
                end
            end
        end
        if (n_comb == '0)
            n_comb = CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_cap)
        begin
            for (int c = 0; c < 3; c++)
                sum_reg[c] <= sum_comb[c];
            n_reg <= n_comb;
        end
    end

    // restoring divider, three channels in parallel, one quotient bit a step
    always_ff @(posedge clk)
    begin
        logic [DEN_W:0] rem_sh;
        if (cmd.div_start)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= {sum_reg[c], 1'b0} + NUM_W'(n_reg);
                rem_reg[c] <= '0;
            end
            den_reg  <= {n_reg, 1'b0};
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem_sh = {rem_reg[c], num_reg[c][NUM_W-1]};
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg[c] <= DEN_W'(rem_sh - {1'b0, den_reg});
                    num_reg[c] <= {num_reg[c][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= rem_sh[DEN_W-1:0];
                    num_reg[c] <= {num_reg[c][NUM_W-2:0], 1'b0};
                end
            end
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {num_reg[2][CH_W-1:0], num_reg[1][CH_W-1:0],
                             num_reg[0][CH_W-1:0]};
            out_last_reg <= last_px;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: src/bb3_ctrl.sv
// ---------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: accept, window update, sum, divide, hand off to output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire bb3_pkg::status_t  status,
    output bb3_pkg::cmd_t          cmd
);
    import bb3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.drop)
                        state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd     = 1'b1;
                cmd.sum_cap = status.emit && status.ci_zero;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_cap = status.emit && !status.ci_zero;
                state_next  = status.emit ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/box_blur_3x3_rgb_top.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// Streaming 3x3 edge-normalized box blur over RGB pixels in raster order.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one beat per pixel (tdata blue/green/red, tuser mode).
//   A drain beat (mode 1) flushes one pending result once the frame's pixels
//   are in; before that it is dropped. m_* channel gives one rounded mean per
//   pixel, tlast on the last pixel of the frame. Results trail input by one
//   row plus one pixel, so width+1 drain beats finish a frame.
//   Sequence: a beat that yields a result goes through window update, sum,
//   the 13-step shared divider and output load before the next accept;
//   m_tvalid is registered and rises after the output load. A beat without
//   result takes update and sum only; a dropped drain beat stays at accept.
//   The result sits in an output register, so the next pixel is accepted
//   while it waits; a further result waits in the sequencer until m_tready.
//   APB: width at 0x0, height at 0x4; a write restarts the frame counters.
//   Reset: width 1024, height 768, counters and window cleared, no result.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [23:0]                 s_tdata,   // in_blue, in_green, in_red
    input  wire logic                        s_tuser,   // mode
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata,   // out_blue, out_green, out_red
    output logic                             m_tlast,   // frame_end
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bb3_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import bb3_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    bb3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bb3_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule

`default_nettype wire

// File: src/bb3_checker.sv
// ---------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_rgb_top_defines.svh"

module bb3_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tready,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [23:0]                 m_tdata,
    input  wire logic                        m_tlast,
    input  wire logic                        psel,
    input  wire logic                        pready
);
    // stalled beat holds
    `BB3_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `BB3_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    // a result is loaded only by the sequencer, never while it takes input
    `BB3_ASSERT_NOW(a_load_busy, $rose(m_tvalid), !$past(s_tready))
    `BB3_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (.*);

`default_nettype wire
